// ===== sv/ash_pkg.sv =====
// Shared constants, types and the bin-edge cosine table of the angular separation histogram.
`default_nettype none

package ash_pkg;

  // Default sizing of the top level
  localparam int DEF_NUM_BINS    = 360;
  localparam int DEF_COUNT_WIDTH = 40;
  localparam int DEF_COORD_WIDTH = 16;

  // Fixed field widths
  localparam int ACTION_W  = 2;
  localparam int BIN_SEL_W = 9;

  // Angular resolution of the edge table
  localparam int BINS_PER_DEGREE = 4;
  localparam int HALF_TURN       = 180 * BINS_PER_DEGREE;
  localparam int MAX_BINS        = 720;

  // Q2.30 dot product, Q2.30 table entries, sum of three Q2.30 terms
  localparam int DOT_W = 32;
  localparam int ACC_W = 34;
  localparam int FRAC_Q30 = 30;
  localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(64'sd1 <<< FRAC_Q30);

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_ACCUM = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // Taylor series constants, Q4.60
  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_DIV  = PI_Q60 / HALF_TURN;
  localparam logic [63:0] PI_MOD  = PI_Q60 % HALF_TURN;

  typedef logic signed [DOT_W-1:0] cos_table_t [MAX_BINS];

  // (a * b) >> 60, kept to 64 bits
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // |cos| in Q2.30 of u half-turn steps, u in [0, HALF_TURN/2]
  function automatic logic signed [DOT_W-1:0] cos_mag_q30(logic [63:0] u);
    logic [63:0]        t;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic [63:0]        rnd;
    logic signed [63:0] sum;
    t    = PI_DIV * u + (PI_MOD * u) / HALF_TURN;
    t2   = mul_q60(t, t);
    term = ONE_Q60;
    sum  = $signed(ONE_Q60);
    for (int k = 1; k <= 40; k++) begin
      if (term != 64'd0) begin
        term = mul_q60(term, t2) / 64'((2 * k - 1) * (2 * k));
        if (k[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > $signed(ONE_Q60)) begin
      sum = $signed(ONE_Q60);
    end
    rnd = ($unsigned(sum) + (64'd1 << 29)) >> FRAC_Q30;
    return DOT_W'(rnd);
  endfunction

  // Entry e-1 holds the cosine of edge e; edges past a half turn never match
  function automatic cos_table_t build_cos_table();
    cos_table_t tab;
    for (int e = 1; e <= MAX_BINS; e++) begin
      if (e > HALF_TURN) begin
        tab[e-1] = -DOT_W'(64'sd1 <<< FRAC_Q30) - DOT_W'(1);
      end else if (e <= HALF_TURN / 2) begin
        tab[e-1] = cos_mag_q30(64'(e));
      end else begin
        tab[e-1] = -cos_mag_q30(64'(HALF_TURN - e));
      end
    end
    return tab;
  endfunction

  localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

`default_nettype wire

// ===== sv/ash_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ash_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 360,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [ADDR_W-1:0]        wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [ADDR_W-1:0]        rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ash_cos_rom.sv =====
// Bin-edge cosine ROM with registered read, entry i is the edge of bin i+1.
`default_nettype none

module ash_cos_rom #(
  parameter int DEPTH = 360,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rd_en,
  input  wire logic [ADDR_W-1:0]               rd_addr,
  output      logic signed [ash_pkg::DOT_W-1:0] rd_data
);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ash_pkg::COS_TABLE[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ash_dot_unit.sv =====
// Dot product unit: one shared multiplier for all three products, Q2.30 sum clamped to +-1.0.
`default_nettype none

module ash_dot_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [COORD_WIDTH-1:0]     first_x,
  input  wire logic signed [COORD_WIDTH-1:0]     first_y,
  input  wire logic signed [COORD_WIDTH-1:0]     first_z,
  input  wire logic signed [COORD_WIDTH-1:0]     second_x,
  input  wire logic signed [COORD_WIDTH-1:0]     second_y,
  input  wire logic signed [COORD_WIDTH-1:0]     second_z,
  output      logic                              done,
  output      logic signed [ash_pkg::DOT_W-1:0]  dot
);

  localparam int PROD_W    = 2 * COORD_WIDTH;
  localparam int PROD_FRAC = 2 * (COORD_WIDTH - 1);
  localparam int SHR = (PROD_FRAC >= ash_pkg::FRAC_Q30) ? PROD_FRAC - ash_pkg::FRAC_Q30 : 0;
  localparam int SHL = (PROD_FRAC >= ash_pkg::FRAC_Q30) ? 0 : ash_pkg::FRAC_Q30 - PROD_FRAC;

  logic                             busy;
  logic [1:0]                       step;
  logic signed [COORD_WIDTH-1:0]    op_a;
  logic signed [COORD_WIDTH-1:0]    op_b;
  logic signed [PROD_W-1:0]         prod;
  logic signed [ash_pkg::DOT_W-1:0] term;
  logic signed [ash_pkg::ACC_W-1:0] acc;
  logic signed [ash_pkg::ACC_W-1:0] acc_sum;

  always_comb begin
    unique case (step)
      2'd0:    begin op_a = first_x; op_b = second_x; end
      2'd1:    begin op_a = first_y; op_b = second_y; end
      default: begin op_a = first_z; op_b = second_z; end
    endcase
  end

  // Bring the product to Q2.30; right shifts floor
  always_comb begin
    if (PROD_FRAC >= ash_pkg::FRAC_Q30) begin
      term = ash_pkg::DOT_W'(prod >>> SHR);
    end else begin
      term = ash_pkg::DOT_W'(prod) <<< SHL;
    end
  end

  assign acc_sum = acc + ash_pkg::ACC_W'(term);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (step == 2'd3);
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      prod <= op_a * op_b;
      if (step == 2'd1) begin
        acc <= ash_pkg::ACC_W'(term);
      end else if (step == 2'd2) begin
        acc <= acc_sum;
      end else if (step == 2'd3) begin
        if (acc_sum > ash_pkg::ACC_ONE) begin
          dot <= ash_pkg::DOT_W'(ash_pkg::ACC_ONE);
        end else if (acc_sum < -ash_pkg::ACC_ONE) begin
          dot <= -ash_pkg::DOT_W'(ash_pkg::ACC_ONE);
        end else begin
          dot <= ash_pkg::DOT_W'(acc_sum);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/angular_separation_histogram_unit.sv =====
// Accumulate: dot product, binary search, histogram update; a pair past the last bin skips
//   the update. Read or read-and-clear: histogram access; a bad index goes straight to the result.
// Throughput: one item at a time, the next beat taken the cycle after the result loads;
//   the dot product, then binary search steps that each read the registered cosine ROM
//   (ST_SRCH_RD) and compare (ST_SRCH_CMP), then one read-modify-write of the histogram RAM.
// Reset: synchronous; a clearing pass zeroes every histogram bin, s_tready low.
`default_nettype none

module angular_separation_histogram_unit #(
  parameter int NUM_BINS    = ash_pkg::DEF_NUM_BINS,
  parameter int COUNT_WIDTH = ash_pkg::DEF_COUNT_WIDTH,
  parameter int COORD_WIDTH = ash_pkg::DEF_COORD_WIDTH,
  localparam int IN_BITS    = 6 * COORD_WIDTH + ash_pkg::BIN_SEL_W,
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = ash_pkg::BIN_SEL_W + COUNT_WIDTH,
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, bin_select, zero pad
  input  wire logic [IN_DATA_W-1:0]          s_tdata,
  // action
  input  wire logic [ash_pkg::ACTION_W-1:0]  s_tuser,
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  // bin_number, bin_count, zero pad
  output      logic [OUT_DATA_W-1:0]         m_tdata,
  // out_of_range
  output      logic [0:0]                    m_tuser
);

  localparam int ADDR_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CNT_W      = $clog2(NUM_BINS + 1);
  localparam int SEL_LSB    = 6 * COORD_WIDTH;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_DOT      = 3'd2;
  localparam logic [2:0] ST_SRCH_RD  = 3'd3;
  localparam logic [2:0] ST_SRCH_CMP = 3'd4;
  localparam logic [2:0] ST_READ     = 3'd5;
  localparam logic [2:0] ST_MOD      = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  logic [2:0]                        state;
  logic [2:0]                        state_next;
  logic [ADDR_W-1:0]                 clr_idx;
  logic                              in_fire;
  logic                              out_load;

  logic [ash_pkg::ACTION_W-1:0]      act_in;
  logic [ash_pkg::BIN_SEL_W-1:0]     sel_in;
  logic                              sel_bad;

  logic [ash_pkg::ACTION_W-1:0]      act_q;
  logic signed [COORD_WIDTH-1:0]     coord_q [6];
  logic [ADDR_W-1:0]                 addr_q;
  logic [CNT_W-1:0]                  lo;
  logic [CNT_W-1:0]                  hi;
  logic [CNT_W-1:0]                  mid;
  logic                              search_on;
  logic                              search_miss;

  logic [ash_pkg::BIN_SEL_W-1:0]     res_bin;
  logic [COUNT_WIDTH-1:0]            res_count;
  logic                              res_flag;
  logic [ash_pkg::BIN_SEL_W-1:0]     bin_number_q;
  logic [COUNT_WIDTH-1:0]            bin_count_q;
  logic                              oor_q;

  logic                              dot_start;
  logic                              dot_done;
  logic signed [ash_pkg::DOT_W-1:0]  dot;
  logic signed [ash_pkg::DOT_W-1:0]  edge_cos;

  logic                              ram_wr_en;
  logic [ADDR_W-1:0]                 ram_wr_addr;
  logic [COUNT_WIDTH-1:0]            ram_wr_data;
  logic                              ram_rd_en;
  logic [COUNT_WIDTH-1:0]            ram_rd_data;
  logic [COUNT_WIDTH-1:0]            count_inc;
  logic                              act_writes;

  assign act_in   = s_tuser;
  assign sel_in   = s_tdata[SEL_LSB +: ash_pkg::BIN_SEL_W];
  assign sel_bad  = (sel_in >= NUM_BINS);
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  assign mid         = CNT_W'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign search_on   = (lo < hi);
  assign search_miss = (lo >= NUM_BINS);

  assign dot_start = in_fire && (act_in == ash_pkg::ACT_ACCUM);

  // Saturate at all ones
  assign count_inc  = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + COUNT_WIDTH'(1);
  assign act_writes = (act_q == ash_pkg::ACT_ACCUM) || (act_q == ash_pkg::ACT_CLEAR);

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = addr_q;
    ram_wr_data = '0;
    if (state == ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_idx;
    end else if (state == ST_MOD) begin
      ram_wr_en = act_writes;
      if (act_q == ash_pkg::ACT_ACCUM) begin
        ram_wr_data = count_inc;
      end
    end
  end

  assign ram_rd_en = (state == ST_READ);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == ADDR_W'(NUM_BINS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (act_in == ash_pkg::ACT_ACCUM) begin
            state_next = ST_DOT;
          end else if (sel_bad) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_DOT: begin
        if (dot_done) begin
          state_next = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (search_on) begin
          state_next = ST_SRCH_CMP;
        end else if (search_miss) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_SRCH_CMP: state_next = ST_SRCH_RD;
      ST_READ:     state_next = ST_MOD;
      ST_MOD:      state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + ADDR_W'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 6; i++) begin
        coord_q[i] <= s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
      end
      act_q     <= act_in;
      addr_q    <= ADDR_W'(sel_in);
      res_bin   <= sel_in;
      res_count <= '0;
      res_flag  <= (act_in != ash_pkg::ACT_ACCUM) && sel_bad;
    end
    if ((state == ST_DOT) && dot_done) begin
      lo <= '0;
      hi <= CNT_W'(NUM_BINS);
    end
    if ((state == ST_SRCH_RD) && !search_on) begin
      addr_q    <= ADDR_W'(lo);
      res_bin   <= search_miss ? '0 : ash_pkg::BIN_SEL_W'(lo);
      res_count <= '0;
      res_flag  <= search_miss;
    end
    // Edge on or above the dot product: the pair lies past this edge
    if (state == ST_SRCH_CMP) begin
      if (dot <= edge_cos) begin
        lo <= mid + CNT_W'(1);
      end else begin
        hi <= mid;
      end
    end
    if (state == ST_MOD) begin
      res_count <= (act_q == ash_pkg::ACT_ACCUM) ? count_inc : ram_rd_data;
    end
    if (out_load) begin
      bin_number_q <= res_bin;
      bin_count_q  <= res_count;
      oor_q        <= res_flag;
    end
  end

  assign m_tdata = OUT_DATA_W'({bin_count_q, bin_number_q});
  assign m_tuser = oor_q;

  ash_dot_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dot (
    .clk      (clk),
    .rst      (rst),
    .start    (dot_start),
    .first_x  (coord_q[0]),
    .first_y  (coord_q[1]),
    .first_z  (coord_q[2]),
    .second_x (coord_q[3]),
    .second_y (coord_q[4]),
    .second_z (coord_q[5]),
    .done     (dot_done),
    .dot      (dot)
  );

  ash_cos_rom #(
    .DEPTH (NUM_BINS)
  ) u_cos_rom (
    .clk     (clk),
    .rd_en   (state == ST_SRCH_RD),
    .rd_addr (ADDR_W'(mid)),
    .rd_data (edge_cos)
  );

  ash_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (addr_q),
    .rd_data (ram_rd_data)
  );

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_CMP) |-> (lo < hi) && (hi <= NUM_BINS))
    else $error("search compare with empty or oversized interval");

  a_dot_done_state: assert property (@(posedge clk) disable iff (rst)
    dot_done |-> (state == ST_DOT))
    else $error("dot product finished outside its wait state");

  a_wr_addr_range: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (ram_wr_addr < NUM_BINS))
    else $error("histogram write beyond last bin");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_flag) |=> (bin_count_q == '0))
    else $error("flagged beat carries a nonzero count");

endmodule

`default_nettype wire

// ===== tb/ash_checker.sv =====
// Scoreboard for the angular separation histogram: predicts every result beat and compares it.
`timescale 1ns / 1ps

module ash_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, bin_select, zero pad
  input  wire logic [111:0] s_tdata,
  // action
  input  wire logic [1:0]   s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  // bin_number, bin_count, zero pad
  input  wire logic [55:0]  m_tdata,
  // out_of_range
  input  wire logic [0:0]   m_tuser,
  output int                errors,
  output int                pending,
  output int                results,
  output int                oor_seen,
  output int                bins_hit
);

  localparam int BINS       = 360;
  localparam int CNT_W      = 40;
  localparam int HALF_STEPS = 720;
  localparam logic [63:0] PI_Q4_60 = 64'h3243F6A8885A308D;
  localparam longint Q30_ONE = 64'sd1 <<< 30;
  localparam logic [CNT_W-1:0] CNT_FULL = '1;

  typedef struct packed {
    logic [8:0]       bin;
    logic [CNT_W-1:0] count;
    logic             oor;
  } bin_result_t;

  longint           edge_cos [BINS];
  logic [CNT_W-1:0] tally [BINS];
  logic [BINS-1:0]  hit_map;
  bin_result_t      expected_bins [$];

  assign bins_hit = $countones(hit_map);

  // (a * b) >> 60 on unsigned Q4.60 values, truncated to 64 bits
  function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[123:60];
  endfunction

  // |cos| in Q2.30 of u steps of a quarter degree, from a truncated Taylor series
  function automatic longint edge_cosine_mag(input longint u);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    longint      acc;
    ang    = (PI_Q4_60 / 64'(HALF_STEPS)) * 64'(u)
           + ((PI_Q4_60 % 64'(HALF_STEPS)) * 64'(u)) / 64'(HALF_STEPS);
    ang_sq = q60_product(ang, ang);
    term   = 64'd1 << 60;
    acc    = longint'(term);
    for (int k = 1; k <= 40; k++) begin
      if (term != 64'd0) begin
        term = q60_product(term, ang_sq) / 64'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 60)) acc = 64'sd1 <<< 60;
    return longint'((64'(acc) + (64'd1 << 29)) >> 30);
  endfunction

  initial begin
    for (int e = 1; e <= BINS; e++) begin
      if (e > HALF_STEPS) begin
        edge_cos[e-1] = -Q30_ONE - 1;
      end else if (e <= HALF_STEPS / 2) begin
        edge_cos[e-1] = edge_cosine_mag(e);
      end else begin
        edge_cos[e-1] = -edge_cosine_mag(HALF_STEPS - e);
      end
    end
  end

  // Apply one input beat to the shadow histogram and return the result it must produce
  function automatic bin_result_t histogram_step(input logic [1:0] act, input logic [111:0] d);
    bin_result_t r;
    longint      dot;
    int          lo;
    int          hi;
    int          mid;
    logic [8:0]  sel;
    r = '0;
    if (act == ash_pkg::ACT_ACCUM) begin
      dot = longint'($signed(d[15:0])) * longint'($signed(d[63:48]))
          + longint'($signed(d[31:16])) * longint'($signed(d[79:64]))
          + longint'($signed(d[47:32])) * longint'($signed(d[95:80]));
      if (dot > Q30_ONE) dot = Q30_ONE;
      if (dot < -Q30_ONE) dot = -Q30_ONE;
      // bin = number of edges whose cosine is at or above the dot product
      lo = 0;
      hi = BINS;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (dot <= edge_cos[mid]) lo = mid + 1;
        else hi = mid;
      end
      if (lo >= BINS) begin
        r.oor = 1'b1;
      end else begin
        if (tally[lo] != CNT_FULL) tally[lo] = tally[lo] + 1'b1;
        hit_map[lo] = 1'b1;
        r.bin   = 9'(lo);
        r.count = tally[lo];
      end
    end else begin
      sel   = d[104:96];
      r.bin = sel;
      if (sel >= BINS) begin
        r.oor = 1'b1;
      end else begin
        r.count = tally[sel];
        if (act == ash_pkg::ACT_CLEAR) tally[sel] = '0;
      end
    end
    return r;
  endfunction

  task automatic report(input string msg);
    if (errors < 40) $display("chk: %s", msg);
    errors++;
  endtask

  always @(posedge clk) begin
    bin_result_t got;
    bin_result_t want;
    if (rst) begin
      for (int i = 0; i < BINS; i++) tally[i] = '0;
      hit_map = '0;
      expected_bins.delete();
      errors   = 0;
      results  = 0;
      oor_seen = 0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.bin   = m_tdata[8:0];
        got.count = m_tdata[48:9];
        got.oor   = m_tuser[0];
        results++;
        if (expected_bins.size() == 0) begin
          report($sformatf("unexpected beat: bin %0d count %0d flag %0b",
                           got.bin, got.count, got.oor));
        end else begin
          want = expected_bins.pop_front();
          if (got.bin !== want.bin)
            report($sformatf("bin_number %0d, want %0d", got.bin, want.bin));
          if (got.count !== want.count)
            report($sformatf("bin_count %0d, want %0d (bin %0d)", got.count, want.count,
                             want.bin));
          if (got.oor !== want.oor)
            report($sformatf("out_of_range %0b, want %0b (bin %0d)", got.oor, want.oor,
                             want.bin));
          if (want.oor) oor_seen++;
        end
      end
      if (s_tvalid && s_tready) expected_bins.push_back(histogram_step(s_tuser, s_tdata));
      pending <= expected_bins.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives pair, bin-read and bin-clear beats into the histogram unit and reports the verdict.
`timescale 1ns / 1ps

module tb;

  localparam int IN_W         = 112;
  localparam int OUT_W        = 56;
  localparam int RANDOM_ITEMS = 1600;
  localparam logic [1:0] ACT_UNDEF = 2'd3;
  localparam real PI = 3.14159265358979323846;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic [1:0]       s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic [0:0]       m_tuser;

  int errors;
  int pending;
  int results;
  int oor_seen;
  int bins_hit;
  int items_sent;
  bit idling;
  bit long_hold;

  angular_separation_histogram_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ash_checker u_chk (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending),
    .results  (results),
    .oor_seen (oor_seen),
    .bins_hit (bins_hit)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        m_tready = 1'b0;
        repeat (400) @(negedge clk);
      end else if (idling && $urandom_range(0, 2) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
        repeat ($urandom_range(0, 24)) @(negedge clk);
      end
    end
  end

  function automatic logic [5:0][15:0] pair_of(input int ax, input int ay, input int az,
                                               input int bx, input int by, input int bz);
    return {16'(bz), 16'(by), 16'(bx), 16'(az), 16'(ay), 16'(ax)};
  endfunction

  function automatic logic [15:0] to_q15(input real r);
    return 16'($rtoi(r >= 0.0 ? r + 0.5 : r - 0.5));
  endfunction

  // Hold the beat until accepted, then maybe drop valid for a gap
  task automatic send_beat(input logic [1:0] act, input logic [5:0][15:0] vec,
                           input logic [8:0] sel);
    s_tuser  = act;
    s_tdata  = {7'd0, sel, vec};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
    if (idling && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  // Two directions with a chosen separation of 0 to 96 degrees
  task automatic aimed_pair(output logic [5:0][15:0] vec);
    real t, p, d, s, ux, uy, uz, wx, wy;
    t  = $urandom_range(0, 35999) * PI / 18000.0;
    p  = (real'($urandom_range(0, 18000)) - 9000.0) * PI / 18000.0;
    d  = $urandom_range(0, 9600) * PI / 18000.0;
    s  = ($urandom_range(0, 3) == 0) ? 32767.0 * $urandom_range(900, 1000) / 1000.0 : 32767.0;
    ux = $cos(t) * $cos(p);
    uy = $sin(t) * $cos(p);
    uz = $sin(p);
    wx = -$sin(t);
    wy = $cos(t);
    vec[0] = to_q15(s * ux);
    vec[1] = to_q15(s * uy);
    vec[2] = to_q15(s * uz);
    vec[3] = to_q15(s * ($cos(d) * ux + $sin(d) * wx));
    vec[4] = to_q15(s * ($cos(d) * uy + $sin(d) * wy));
    vec[5] = to_q15(s * $cos(d) * uz);
  endtask

  // Pair whose dot product lands on bin edge e, nudged by a few LSBs
  task automatic edge_pair(input int e, input int nudge, output logic [5:0][15:0] vec);
    longint target, k, rest;
    target = u_chk.edge_cos[e-1] + nudge;
    if (target < 0) target = 0;
    if (target > (64'sd1 <<< 30)) target = 64'sd1 <<< 30;
    k = longint'($sqrt(real'(target)));
    while (k * k > target) k--;
    while ((k + 1) * (k + 1) <= target) k++;
    rest = target - k * k;
    vec    = '0;
    vec[0] = (k == 32768) ? 16'h8000 : 16'(k);
    if ($urandom_range(0, 1)) vec[0] = -vec[0];
    vec[3] = vec[0];
    vec[1] = 16'd1;
    vec[2] = 16'd1;
    vec[4] = 16'(rest / 2);
    vec[5] = 16'(rest - rest / 2);
  endtask

  task automatic random_pair(output logic [5:0][15:0] vec);
    case ($urandom_range(0, 9))
      0: for (int i = 0; i < 6; i++) vec[i] = 16'($urandom);
      1: edge_pair($urandom_range(1, 360), int'($urandom_range(0, 2)) - 1, vec);
      default: aimed_pair(vec);
    endcase
  endtask

  task automatic random_beat();
    logic [5:0][15:0] vec;
    logic [8:0]       sel;
    int               pick;
    random_pair(vec);
    sel  = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(360, 511))
                                       : 9'($urandom_range(0, 359));
    pick = $urandom_range(0, 99);
    if (pick < 70) send_beat(ash_pkg::ACT_ACCUM, vec, sel);
    else if (pick < 85) send_beat(ash_pkg::ACT_READ, vec, sel);
    else if (pick < 95) send_beat(ash_pkg::ACT_CLEAR, vec, sel);
    else send_beat(ACT_UNDEF, vec, sel);
  endtask

  initial begin
    logic [5:0][15:0] vec;
    int               edges [4];
    edges      = '{1, 180, 359, 360};
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = ash_pkg::ACT_ACCUM;
    idling     = 1'b0;
    long_hold  = 1'b0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty reads, bad indexes, clamped and perpendicular pairs, exact edges
    random_pair(vec);
    send_beat(ash_pkg::ACT_READ, vec, 9'd0);
    send_beat(ash_pkg::ACT_READ, vec, 9'd359);
    send_beat(ash_pkg::ACT_CLEAR, vec, 9'd360);
    send_beat(ash_pkg::ACT_READ, vec, 9'd511);
    send_beat(ash_pkg::ACT_ACCUM, pair_of(32767, 0, 0, 32767, 0, 0), 9'd511);
    send_beat(ash_pkg::ACT_ACCUM, pair_of(-32768, -32768, -32768, -32768, -32768, -32768),
              9'd0);
    send_beat(ash_pkg::ACT_ACCUM, pair_of(32767, 32767, 32767, -32768, -32768, -32768),
              9'd0);
    send_beat(ash_pkg::ACT_ACCUM, pair_of(32767, 0, 0, 0, 32767, 0), 9'd0);
    send_beat(ash_pkg::ACT_ACCUM, pair_of(32767, 32767, 0, 32767, 0, 0), 9'd0);
    send_beat(ash_pkg::ACT_ACCUM, pair_of(-1, -1, -1, 1, 1, 1), 9'd0);
    foreach (edges[i]) begin
      edge_pair(edges[i], 0, vec);
      send_beat(ash_pkg::ACT_ACCUM, vec, 9'd0);
      edge_pair(edges[i], 1, vec);
      send_beat(ash_pkg::ACT_ACCUM, vec, 9'd0);
    end
    send_beat(ash_pkg::ACT_READ, vec, 9'd0);
    send_beat(ACT_UNDEF, vec, 9'd0);
    send_beat(ash_pkg::ACT_CLEAR, vec, 9'd0);
    send_beat(ash_pkg::ACT_READ, vec, 9'd0);

    idling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) begin
        // drain completely before going on
        s_tvalid = 1'b0;
        do @(negedge clk); while (pending != 0);
      end
      if (n == 900) long_hold = 1'b1;
      if (n == RANDOM_ITEMS - 200) idling = 1'b0;
      random_beat();
    end
    s_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);

    $display("tb: %0d beats sent, %0d results checked, %0d of them flagged out of range",
             items_sent, results, oor_seen);
    $display("tb: %0d of 360 bins counted into, with exact edge, clamped and cleared cases",
             bins_hit);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
